[design/wts_pkg.sv]
// ----------------------------------------------------------------------------
// wts_pkg
// Shared types and constants of the whitespace token splitter.
// ----------------------------------------------------------------------------
`default_nettype none

package wts_pkg;

    // Width of the internal token length counter.
    localparam int LENGTH_BITS = 16;

    // Width of the token length field on the result channel.
    localparam int OUT_LEN_BITS = 16;

    // Width of the configuration register index and data.
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 1;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_HIGH_BYTES_SEPARATE = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_COMMENTS_ENABLED    = 1'd1;

    typedef logic [LENGTH_BITS-1:0] t_len;

    // One result beat.
    typedef struct packed {
        logic                    char_valid;
        logic [7:0]              token_char;
        logic                    token_begins;
        logic                    token_ends;
        logic [OUT_LEN_BITS-1:0] token_length;
        logic                    was_quoted;
        logic                    last_of_run;
    } t_result;

endpackage : wts_pkg

`default_nettype wire

[design/wts_in_if.sv]
// ----------------------------------------------------------------------------
// wts_in_if
// Text byte channel: valid/ready handshake with the byte and a final mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface wts_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       final_byte;

    modport source (output valid, output byte_in, output final_byte, input ready);
    modport sink   (input valid, input byte_in, input final_byte, output ready);
endinterface : wts_in_if

`default_nettype wire

[design/wts_out_if.sv]
// ----------------------------------------------------------------------------
// wts_out_if
// Token result channel: valid/ready handshake with one token beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface wts_out_if;
    logic        valid;
    logic        ready;
    logic        char_valid;
    logic [7:0]  token_char;
    logic        token_begins;
    logic        token_ends;
    logic [15:0] token_length;
    logic        was_quoted;
    logic        last_of_run;

    modport source (
        output valid, output char_valid, output token_char, output token_begins,
        output token_ends, output token_length, output was_quoted,
        output last_of_run, input ready
    );
    modport sink (
        input valid, input char_valid, input token_char, input token_begins,
        input token_ends, input token_length, input was_quoted,
        input last_of_run, output ready
    );
endinterface : wts_out_if

`default_nettype wire

[design/wts_scanner.sv]
// ----------------------------------------------------------------------------
// wts_scanner
// Scan state, configuration registers and the per-byte decode that yields
// up to two result beats.
// ----------------------------------------------------------------------------
`default_nettype none

module wts_scanner (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [wts_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire logic [wts_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    input  wire logic                               i_fire,
    input  wire logic [7:0]                         i_byte,
    input  wire logic                               i_final,
    output      logic [1:0]                         o_num,
    output      wts_pkg::t_result                   o_res0,
    output      wts_pkg::t_result                   o_res1
);
    import wts_pkg::*;

    localparam logic [2:0] MODE_BETWEEN = 3'd0;
    localparam logic [2:0] MODE_SLASH   = 3'd1;
    localparam logic [2:0] MODE_COMMENT = 3'd2;
    localparam logic [2:0] MODE_PLAIN   = 3'd3;
    localparam logic [2:0] MODE_QUOTED  = 3'd4;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_NUL    = 8'h00;

    localparam t_len LEN_MAX = '1;

    typedef struct packed {
        logic [2:0] mode;
        logic       qdbl;
        t_len       len;
        logic [1:0] num;
        t_result    res0;
        t_result    res1;
    } t_scan;

    logic [2:0] r_mode;
    logic       r_qdbl;
    t_len       r_len;
    logic       r_hbs;
    logic       r_cmt;
    logic       sep;
    t_scan      s;

    // Clamp the counter to the width of the output field.
    function automatic logic [OUT_LEN_BITS-1:0] out_len(t_len c);
        logic [32:0] w;
        w = 33'(c);
        return (w > 33'(16'hFFFF)) ? 16'hFFFF : w[OUT_LEN_BITS-1:0];
    endfunction

    function automatic t_scan push_char(t_scan st, logic [7:0] ch, logic q);
        t_result r;
        logic    first;
        first = (st.len == '0);
        r     = '0;
        if (st.num != 2'd2) begin
            if (st.len != LEN_MAX) begin
                st.len = st.len + LENGTH_BITS'(1);
            end
            r.char_valid   = 1'b1;
            r.token_char   = ch;
            r.token_begins = first;
            r.token_length = out_len(st.len);
            r.was_quoted   = q;
            if (st.num == 2'd0) begin
                st.res0 = r;
            end else begin
                st.res1 = r;
            end
            st.num = st.num + 2'd1;
        end
        return st;
    endfunction

    // A token end rides on the byte just pushed when there is one;
    // otherwise it becomes a beat of its own.
    function automatic t_scan close_token(t_scan st);
        t_result r;
        t_result last;
        r    = '0;
        last = (st.num == 2'd2) ? st.res1 : st.res0;
        if (st.num != 2'd0 && last.char_valid && !last.token_ends) begin
            if (st.num == 2'd2) begin
                st.res1.token_ends = 1'b1;
            end else begin
                st.res0.token_ends = 1'b1;
            end
        end else if (st.num != 2'd2) begin
            r.token_begins = (st.len == '0);
            r.token_ends   = 1'b1;
            r.token_length = out_len(st.len);
            r.was_quoted   = (st.mode == MODE_QUOTED);
            if (st.num == 2'd0) begin
                st.res0 = r;
            end else begin
                st.res1 = r;
            end
            st.num = st.num + 2'd1;
        end
        st.mode = MODE_BETWEEN;
        st.len  = '0;
        return st;
    endfunction

    assign sep = (i_byte <= CH_SPACE) || (r_hbs && i_byte[7]);

    always_comb begin
        s      = '0;
        s.mode = r_mode;
        s.qdbl = r_qdbl;
        s.len  = r_len;
        case (r_mode)
            MODE_SLASH: begin
                if (i_byte == CH_SLASH) begin
                    s.mode = MODE_COMMENT;
                end else begin
                    s.mode = MODE_PLAIN;
                    s.len  = '0;
                    s      = push_char(s, CH_SLASH, 1'b0);
                    if (sep) begin
                        s = close_token(s);
                    end else begin
                        s = push_char(s, i_byte, 1'b0);
                    end
                end
            end
            MODE_COMMENT: begin
                if (i_byte == CH_NL) begin
                    s.mode = MODE_BETWEEN;
                end
            end
            MODE_PLAIN: begin
                if (sep) begin
                    s = close_token(s);
                end else begin
                    s = push_char(s, i_byte, 1'b0);
                end
            end
            MODE_QUOTED: begin
                if (i_byte == CH_NUL || i_byte == (r_qdbl ? CH_DQUOTE : CH_SQUOTE)) begin
                    s = close_token(s);
                end else begin
                    s = push_char(s, i_byte, 1'b1);
                end
            end
            default: begin
                s.mode = MODE_BETWEEN;
                if (sep) begin
                    s.mode = MODE_BETWEEN;
                end else if (i_byte == CH_SLASH && r_cmt) begin
                    s.mode = MODE_SLASH;
                end else if (i_byte == CH_DQUOTE || i_byte == CH_SQUOTE) begin
                    s.mode = MODE_QUOTED;
                    s.qdbl = (i_byte == CH_DQUOTE);
                    s.len  = '0;
                end else begin
                    s.mode = MODE_PLAIN;
                    s.len  = '0;
                    s      = push_char(s, i_byte, 1'b0);
                end
            end
        endcase

        // End of data: a held slash becomes a token, open tokens close,
        // an open comment is dropped.
        if (i_final) begin
            if (s.mode == MODE_SLASH) begin
                s.mode = MODE_PLAIN;
                s.len  = '0;
                s      = push_char(s, CH_SLASH, 1'b0);
            end
            if (s.mode == MODE_PLAIN || s.mode == MODE_QUOTED) begin
                s = close_token(s);
            end
            s.mode = MODE_BETWEEN;
            s.len  = '0;
        end

        if (s.num == 2'd2) begin
            s.res1.last_of_run = 1'b1;
        end else if (s.num == 2'd1) begin
            s.res0.last_of_run = 1'b1;
        end
    end

    assign o_num  = s.num;
    assign o_res0 = s.res0;
    assign o_res1 = s.res1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_BETWEEN;
            r_qdbl <= 1'b0;
            r_len  <= '0;
            r_hbs  <= 1'b1;
            r_cmt  <= 1'b1;
        end else begin
            if (i_fire) begin
                r_mode <= s.mode;
                r_qdbl <= s.qdbl;
                r_len  <= s.len;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_HIGH_BYTES_SEPARATE: r_hbs <= i_cfg_data[0];
                    CFG_COMMENTS_ENABLED:    r_cmt <= i_cfg_data[0];
                    default:                 r_hbs <= r_hbs;
                endcase
            end
        end
    end

endmodule : wts_scanner

`default_nettype wire

[design/wts_result_buffer.sv]
// ----------------------------------------------------------------------------
// wts_result_buffer
// Holds the result beats of one byte and hands them out one per beat.
// ----------------------------------------------------------------------------
`default_nettype none

module wts_result_buffer (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  wire logic [1:0]       i_num,
    input  wire wts_pkg::t_result i_res0,
    input  wire wts_pkg::t_result i_res1,
    output      logic             o_can_load,
    wts_out_if.source             o_out
);
    import wts_pkg::*;

    t_result    r_res0;
    t_result    r_res1;
    logic [1:0] r_num;
    logic       r_pos;
    logic       pop;
    t_result    head;

    assign pop        = o_out.valid && o_out.ready;
    assign o_can_load = (r_num == 2'd0) || (r_num == 2'd1 && pop);
    assign head       = r_pos ? r_res1 : r_res0;

    assign o_out.valid        = (r_num != 2'd0);
    assign o_out.char_valid   = head.char_valid;
    assign o_out.token_char   = head.token_char;
    assign o_out.token_begins = head.token_begins;
    assign o_out.token_ends   = head.token_ends;
    assign o_out.token_length = head.token_length;
    assign o_out.was_quoted   = head.was_quoted;
    assign o_out.last_of_run  = head.last_of_run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num <= 2'd0;
            r_pos <= 1'b0;
        end else if (i_load) begin
            r_num <= i_num;
            r_pos <= 1'b0;
        end else if (pop) begin
            r_num <= r_num - 2'd1;
            r_pos <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res0 <= i_res0;
            r_res1 <= i_res1;
        end
    end

endmodule : wts_result_buffer

`default_nettype wire

[design/whitespace_token_splitter.sv]
// ----------------------------------------------------------------------------
// whitespace_token_splitter
// Splits a byte stream into tokens at whitespace, with quoted tokens and
// line comments.
// ----------------------------------------------------------------------------
// Usage:
//   Text enters on i_in one byte per beat; final_byte marks the last byte of
//   the data and closes any open token. Token bytes leave on o_out, one beat
//   per result, with begin and end marks, a saturating length and a quoted
//   flag. last_of_run flags the final beat caused by one input byte.
//   An accepted byte is held in an input register, decoded against the
//   scan state, and its results are loaded into a two-entry result buffer
//   that drives o_out. One byte is accepted every cycle while o_out.ready
//   stays high and each byte yields at most one beat. A byte that yields
//   two beats (a held slash followed by a token byte, for instance) keeps
//   the result buffer busy until both are taken, which sets the rate to one
//   byte per result beat in that case. Bytes that yield nothing
//   (separators, comment text) retire without loading the result buffer.
//   When o_out.ready is low, the result buffer holds its beats, the decode
//   stage waits with a byte that has results, and i_in.ready drops once
//   the input register is occupied. Reset clears the scan state to between
//   tokens, empties both stages and sets both configuration registers to 1.
//   Configuration is written through i_cfg_* only while the block is idle;
//   the user must keep to this, the block itself does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module whitespace_token_splitter (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [wts_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire logic [wts_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    wts_in_if.sink                                  i_in,
    wts_out_if.source                               o_out
);
    import wts_pkg::*;

    // Input register: one byte waiting for decode.
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_final;

    logic       fire;
    logic       can_load;
    logic [1:0] scan_num;
    t_result    scan_res0;
    t_result    scan_res1;

    // The decode stage retires its byte when the byte has no results, or
    // when the result buffer is free (or frees up this cycle).
    assign fire       = r_in_valid && (scan_num == 2'd0 || can_load);
    assign i_in.ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_byte  <= i_in.byte_in;
            r_in_final <= i_in.final_byte;
        end
    end

    wts_scanner u_scanner (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_fire      (fire),
        .i_byte      (r_in_byte),
        .i_final     (r_in_final),
        .o_num       (scan_num),
        .o_res0      (scan_res0),
        .o_res1      (scan_res1)
    );

    wts_result_buffer u_result_buffer (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (fire && scan_num != 2'd0),
        .i_num      (scan_num),
        .i_res0     (scan_res0),
        .i_res1     (scan_res1),
        .o_can_load (can_load),
        .o_out      (o_out)
    );

endmodule : whitespace_token_splitter

`default_nettype wire

[verif/wts_token_checker.sv]
// ----------------------------------------------------------------------------
// wts_token_checker
// Watches the byte and token channels of the token splitter, predicts each
// token beat from the accepted bytes and compares it with what comes out.
// ----------------------------------------------------------------------------
`default_nettype none

module wts_token_checker (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [wts_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire logic [wts_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    wts_in_if                                       in_mon,
    wts_out_if                                      out_mon,
    output int                                      o_fail_count,
    output int                                      o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import wts_pkg::*;

    typedef enum logic [2:0] {
        SCAN_BETWEEN = 3'd0,
        SCAN_SLASH   = 3'd1,
        SCAN_COMMENT = 3'd2,
        SCAN_PLAIN   = 3'd3,
        SCAN_QUOTED  = 3'd4
    } scan_mode_e;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_SQUOTE  = 8'h27;
    localparam logic [7:0] CH_SLASH   = 8'h2F;

    logic       high_sep;
    logic       comments_on;
    scan_mode_e scan_mode;
    logic       quote_double;
    t_len       tok_len;

    t_result    step_beats [2];
    int         step_count;
    t_result    token_beats_q [$];
    int         mismatch_count;

    assign o_fail_count = mismatch_count;

    function automatic logic is_separator(logic [7:0] b);
        return (b <= CH_SPACE) || (high_sep && b[7]);
    endfunction

    function automatic logic [OUT_LEN_BITS-1:0] reported_length(t_len n);
        if (LENGTH_BITS > OUT_LEN_BITS && n > t_len'({OUT_LEN_BITS{1'b1}})) return '1;
        return OUT_LEN_BITS'(n);
    endfunction

    // Appends one token byte to the beats of the current step.
    function automatic void emit_char(logic [7:0] ch, logic quoted);
        t_result r;
        if (step_count >= 2) return;
        r = '0;
        r.token_begins = (tok_len == '0);
        if (tok_len != '1) tok_len = tok_len + t_len'(1);
        r.char_valid   = 1'b1;
        r.token_char   = ch;
        r.token_length = reported_length(tok_len);
        r.was_quoted   = quoted;
        step_beats[step_count] = r;
        step_count++;
    endfunction

    // The end mark rides on a byte beat of this step when there is one.
    function automatic void end_token();
        t_result r;
        if (step_count > 0 && step_beats[step_count-1].char_valid
                && !step_beats[step_count-1].token_ends) begin
            step_beats[step_count-1].token_ends = 1'b1;
        end else if (step_count < 2) begin
            r = '0;
            r.token_begins = (tok_len == '0);
            r.token_ends   = 1'b1;
            r.token_length = reported_length(tok_len);
            r.was_quoted   = (scan_mode == SCAN_QUOTED);
            step_beats[step_count] = r;
            step_count++;
        end
        scan_mode = SCAN_BETWEEN;
        tok_len   = '0;
    endfunction

    function automatic void predict_byte(logic [7:0] b, logic fin);
        step_count = 0;
        case (scan_mode)
            SCAN_SLASH: begin
                if (b == CH_SLASH) begin
                    scan_mode = SCAN_COMMENT;
                end else begin
                    scan_mode = SCAN_PLAIN;
                    tok_len   = '0;
                    emit_char(CH_SLASH, 1'b0);
                    if (is_separator(b)) end_token();
                    else emit_char(b, 1'b0);
                end
            end
            SCAN_COMMENT: begin
                if (b == CH_NEWLINE) scan_mode = SCAN_BETWEEN;
            end
            SCAN_PLAIN: begin
                if (is_separator(b)) end_token();
                else emit_char(b, 1'b0);
            end
            SCAN_QUOTED: begin
                if (b == CH_NUL || b == (quote_double ? CH_DQUOTE : CH_SQUOTE)) end_token();
                else emit_char(b, 1'b1);
            end
            default: begin
                scan_mode = SCAN_BETWEEN;
                if (is_separator(b)) begin
                    // Separators between tokens are skipped.
                end else if (b == CH_SLASH && comments_on) begin
                    scan_mode = SCAN_SLASH;
                end else if (b == CH_DQUOTE || b == CH_SQUOTE) begin
                    scan_mode    = SCAN_QUOTED;
                    quote_double = (b == CH_DQUOTE);
                    tok_len      = '0;
                end else begin
                    scan_mode = SCAN_PLAIN;
                    tok_len   = '0;
                    emit_char(b, 1'b0);
                end
            end
        endcase

        if (fin) begin
            if (scan_mode == SCAN_SLASH) begin
                scan_mode = SCAN_PLAIN;
                tok_len   = '0;
                emit_char(CH_SLASH, 1'b0);
            end
            if (scan_mode == SCAN_PLAIN || scan_mode == SCAN_QUOTED) end_token();
            scan_mode = SCAN_BETWEEN;
            tok_len   = '0;
        end

        if (step_count > 0) step_beats[step_count-1].last_of_run = 1'b1;
        for (int i = 0; i < step_count; i++) token_beats_q.push_back(step_beats[i]);
    endfunction

    function automatic void compare_field(string field, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : monitor
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            high_sep     = 1'b1;
            comments_on  = 1'b1;
            scan_mode    = SCAN_BETWEEN;
            quote_double = 1'b0;
            tok_len      = '0;
            token_beats_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_HIGH_BYTES_SEPARATE: high_sep    = i_cfg_data[0];
                    CFG_COMMENTS_ENABLED:    comments_on = i_cfg_data[0];
                    default:                 high_sep    = high_sep;
                endcase
            end
            if (in_mon.valid && in_mon.ready) predict_byte(in_mon.byte_in, in_mon.final_byte);
            if (out_mon.valid && out_mon.ready) begin
                got = {out_mon.char_valid, out_mon.token_char, out_mon.token_begins,
                       out_mon.token_ends, out_mon.token_length, out_mon.was_quoted,
                       out_mon.last_of_run};
                if (token_beats_q.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected beat, expected none, actual %h", $time, got);
                end else begin
                    want = token_beats_q.pop_front();
                    compare_field("char_valid",   16'(want.char_valid),   16'(got.char_valid));
                    compare_field("token_char",   16'(want.token_char),   16'(got.token_char));
                    compare_field("token_begins", 16'(want.token_begins), 16'(got.token_begins));
                    compare_field("token_ends",   16'(want.token_ends),   16'(got.token_ends));
                    compare_field("token_length", 16'(want.token_length), 16'(got.token_length));
                    compare_field("was_quoted",   16'(want.was_quoted),   16'(got.was_quoted));
                    compare_field("last_of_run",  16'(want.last_of_run),  16'(got.last_of_run));
                end
            end
        end
        o_pending <= token_beats_q.size();
    end

    initial begin
        mismatch_count = 0;
    end

endmodule : wts_token_checker

`default_nettype wire

[verif/tb_whitespace_token_splitter.sv]
// ----------------------------------------------------------------------------
// tb_whitespace_token_splitter
// Drives text bytes into the token splitter under several register settings,
// with bursty input and a stalling result side, and reports the verdict of
// the checker that runs beside the block.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_whitespace_token_splitter;
    timeunit 1ns;
    timeprecision 1ps;

    import wts_pkg::*;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_SQUOTE  = 8'h27;
    localparam logic [7:0] CH_SLASH   = 8'h2F;

    // Number of random beats on the byte channel, spread over four settings.
    localparam int RANDOM_ITEMS = 1650;
    // Cycles to let pass once nothing is expected, for bytes still in flight.
    localparam int DRAIN_CYCLES = 6;
    // Cycles without any accepted beat after which the run is abandoned.
    localparam int STUCK_LIMIT  = 2000;

    typedef enum int {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PERIODIC,
        STALL_HEAVY
    } stall_style_e;

    typedef enum int {
        SEQ_WORD,
        SEQ_QUOTED,
        SEQ_COMMENT,
        SEQ_SLASH,
        SEQ_SEPARATORS,
        SEQ_NOISE,
        SEQ_FINAL_WORD
    } seq_kind_e;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index;
    logic [CFG_DATA_BITS-1:0]  i_cfg_data;

    wts_in_if  in_ch ();
    wts_out_if out_ch ();

    int fail_count;
    int pending_beats;

    // The stimulus keeps its own copy of the settings so that it can shape
    // well-formed tokens for the separator rules in force.
    logic cur_high_sep;
    logic cur_comments;
    int   burst_left;
    int   random_items;

    whitespace_token_splitter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    wts_token_checker u_token_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .in_mon       (in_ch),
        .out_mon      (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_beats)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Presents one byte and holds it until the block takes it. The sender
    // works in bursts; when a burst runs out, valid may drop for a random gap.
    // Valid gets a single nonblocking update per time step: either it is
    // lowered for a gap, or it is raised (or kept) for the next beat.
    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 4);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            // Now and then a long burst gives a stretch with no idling at all.
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
        end
        in_ch.valid      <= 1'b1;
        in_ch.byte_in    <= b;
        in_ch.final_byte <= fin;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        burst_left--;
    endtask

    // A random beat of the stimulus, with an occasional final mark.
    task automatic put(input logic [7:0] b);
        send_byte(b, $urandom_range(0, 49) == 0);
        random_items++;
    endtask

    // Drops valid and waits until every predicted beat has come out, then
    // waits out the drain time for bytes that cause no beat at all.
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_beats != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Both registers are written on back-to-back cycles while idle.
    task automatic configure(input logic high_sep, input logic comments);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_HIGH_BYTES_SEPARATE;
        i_cfg_data  <= high_sep;
        @(posedge i_clk);
        i_cfg_index <= CFG_COMMENTS_ENABLED;
        i_cfg_data  <= comments;
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
        cur_high_sep = high_sep;
        cur_comments = comments;
    endtask

    // A byte that belongs inside a plain token under the current setting.
    function automatic logic [7:0] word_byte();
        if (!cur_high_sep && $urandom_range(0, 3) == 0) return 8'($urandom_range(128, 255));
        return 8'($urandom_range(33, 126));
    endfunction

    function automatic logic [7:0] separator_byte();
        if (cur_high_sep && $urandom_range(0, 3) == 0) return 8'($urandom_range(128, 255));
        return 8'($urandom_range(0, 32));
    endfunction

    // Random text until the running beat count reaches the target. Most of
    // it is well-formed tokens with random content; the rest is line comments,
    // separator runs, raw noise and tokens cut short by a final mark.
    task automatic random_text(input int target);
        seq_kind_e   kind;
        int          len;
        int          roll;
        logic [7:0]  quote;
        logic [7:0]  b;
        while (random_items < target) begin
            roll = $urandom_range(0, 99);
            kind = (roll < 34) ? SEQ_WORD :
                   (roll < 50) ? SEQ_QUOTED :
                   (roll < 60) ? SEQ_COMMENT :
                   (roll < 68) ? SEQ_SLASH :
                   (roll < 80) ? SEQ_SEPARATORS :
                   (roll < 92) ? SEQ_NOISE : SEQ_FINAL_WORD;
            case (kind)
                SEQ_WORD: begin
                    len = $urandom_range(1, 10);
                    repeat (len) put(word_byte());
                    put(separator_byte());
                end
                SEQ_QUOTED: begin
                    quote = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
                    put(quote);
                    len = $urandom_range(0, 8);
                    repeat (len) begin
                        b = 8'($urandom_range(1, 255));
                        if (b == quote) b = "x";
                        put(b);
                    end
                    // Most quoted tokens close on their quote, a few on a NUL.
                    put(($urandom_range(0, 9) == 0) ? CH_NUL : quote);
                end
                SEQ_COMMENT: begin
                    put(CH_SLASH);
                    put(CH_SLASH);
                    len = $urandom_range(0, 10);
                    repeat (len) begin
                        b = 8'($urandom);
                        if (b == CH_NEWLINE) b = CH_SPACE;
                        put(b);
                    end
                    put(CH_NEWLINE);
                end
                SEQ_SLASH: begin
                    put(CH_SLASH);
                    if ($urandom_range(0, 2) == 0) begin
                        put(separator_byte());
                    end else begin
                        len = $urandom_range(1, 5);
                        repeat (len) put(word_byte());
                        put(separator_byte());
                    end
                end
                SEQ_SEPARATORS: begin
                    // A run of separators between tokens.
                    len = $urandom_range(1, 4);
                    repeat (len) put(separator_byte());
                end
                SEQ_NOISE: begin
                    len = $urandom_range(1, 8);
                    repeat (len) put(8'($urandom));
                end
                default: begin
                    len = $urandom_range(0, 6);
                    if ($urandom_range(0, 1)) put($urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE);
                    repeat (len) put(word_byte());
                    send_byte(word_byte(), 1'b1);
                    random_items++;
                end
            endcase
        end
    endtask

    // Watchdog: abandons the run when neither channel moves a beat for too
    // long, whether the block hangs or a result never arrives.
    initial begin : watchdog
        int stuck_cycles;
        stuck_cycles = 0;
        while (stuck_cycles < STUCK_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                stuck_cycles = 0;
            else
                stuck_cycles++;
        end
        $display("whitespace_token_splitter verification failed");
        $finish;
    end

    // Result side: ready follows a pattern that changes from segment to
    // segment, from always ready through random and periodic stalls to long
    // stretches of mostly stalled output.
    initial begin : result_stall
        stall_style_e style;
        int           seg_left;
        int           period;
        int           low_len;
        int           phase;
        out_ch.ready <= 1'b0;
        style    = STALL_NONE;
        seg_left = 0;
        period   = 2;
        low_len  = 1;
        phase    = 0;
        forever begin
            @(posedge i_clk);
            if (seg_left == 0) begin
                style    = stall_style_e'($urandom_range(0, 3));
                seg_left = $urandom_range(40, 300);
                period   = $urandom_range(2, 9);
                low_len  = $urandom_range(1, period - 1);
                phase    = 0;
            end
            seg_left--;
            case (style)
                STALL_NONE:   out_ch.ready <= 1'b1;
                STALL_RANDOM: out_ch.ready <= ($urandom_range(0, 3) != 0);
                STALL_PERIODIC: begin
                    out_ch.ready <= (phase >= low_len);
                    phase = (phase + 1) % period;
                end
                default:      out_ch.ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    initial begin : stimulus
        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_index      <= CFG_HIGH_BYTES_SEPARATE;
        i_cfg_data       <= '0;
        in_ch.valid      <= 1'b0;
        in_ch.byte_in    <= '0;
        in_ch.final_byte <= 1'b0;
        cur_high_sep = 1'b1;
        cur_comments = 1'b1;
        burst_left   = 0;
        random_items = 0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed text under the reset settings. A plain token closed by a
        // separator.
        send_byte("a", 1'b0);
        send_byte("b", 1'b0);
        send_byte(CH_SPACE, 1'b0);
        // A lone slash that turns into the first byte of a plain token; the
        // slash and the byte after it come out as two beats of one step.
        send_byte(CH_SLASH, 1'b0);
        send_byte("x", 1'b0);
        send_byte(CH_NEWLINE, 1'b0);
        // A line comment, skipped up to and including the newline.
        send_byte(CH_SLASH, 1'b0);
        send_byte(CH_SLASH, 1'b0);
        send_byte("z", 1'b0);
        send_byte(CH_NEWLINE, 1'b0);
        // Empty quotes give a single beat that both begins and ends a token.
        send_byte(CH_DQUOTE, 1'b0);
        send_byte(CH_DQUOTE, 1'b0);
        // A NUL closes a quoted token and is consumed.
        send_byte(CH_SQUOTE, 1'b0);
        send_byte("q", 1'b0);
        send_byte(CH_NUL, 1'b0);
        // A top-bit byte separates; the final mark then closes the token on
        // the same beat as its last byte.
        send_byte(8'hFF, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte("k", 1'b1);
        // A held slash on the final byte becomes a one-byte token.
        send_byte(CH_SLASH, 1'b1);
        // A slash followed by a separator is a one-byte token too.
        send_byte(CH_SLASH, 1'b0);
        send_byte(CH_SPACE, 1'b0);
        // A quoted token left open is closed by the final mark.
        send_byte(CH_DQUOTE, 1'b0);
        send_byte("a", 1'b1);

        // Random text under four settings, the extremes among them.
        configure(1'b0, 1'b0);
        random_text(RANDOM_ITEMS / 4);
        configure(1'b1, 1'b0);
        random_text(RANDOM_ITEMS / 2);
        configure(1'b0, 1'b1);
        random_text(3 * RANDOM_ITEMS / 4);
        configure(1'b1, 1'b1);
        random_text(RANDOM_ITEMS);

        settle();
        if (fail_count == 0) begin
            $display("whitespace_token_splitter verification clean");
        end else begin
            $display("whitespace_token_splitter verification failed");
        end
        $finish;
    end

endmodule : tb_whitespace_token_splitter

`default_nettype wire
